// ----- rtl/core/sqvt_pkg.sv -----
// shared types, constants and the arctangent table of the sprite quad transform
package sqvt_pkg;

    localparam int SQVT_MAX_QUADS    = 1024;
    localparam int SQVT_CORDIC_STEPS = 16;
    localparam int SQVT_QUEUE_DEPTH  = 2;
    localparam int SQVT_INDEX_W      = 10;

    localparam logic [31:0] SQVT_CORDIC_GAIN  = 32'h26DD3B6A;
    localparam logic [31:0] SQVT_HALF_TURN    = 32'h80000000;
    localparam logic [31:0] SQVT_QUARTER_TURN = 32'h40000000;

    localparam logic [1:0] CORNER_BL = 2'd0;
    localparam logic [1:0] CORNER_BR = 2'd1;
    localparam logic [1:0] CORNER_TL = 2'd2;
    localparam logic [1:0] CORNER_TR = 2'd3;

    // one classified quad as it waits between front and back
    typedef struct packed {
        logic signed [31:0]        pos_x;
        logic signed [31:0]        pos_y;
        logic signed [31:0]        size_x;
        logic signed [31:0]        size_y;
        logic [15:0]               angle;
        logic [15:0]               uv_lo_u;
        logic [15:0]               uv_lo_v;
        logic [15:0]               uv_hi_u;
        logic [15:0]               uv_hi_v;
        logic [SQVT_INDEX_W-1:0]   quad_index;
        logic                      overflow;
    } sqvt_quad_t;

    typedef struct packed {
        logic       valid;
        sqvt_quad_t quad;
    } sqvt_qpush_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sqvt_qstat_t;

    typedef struct packed {
        logic       busy;
        logic [1:0] corner;
    } sqvt_back_stat_t;

    // arctangent of 2^-i as a fraction of a full turn (2^32 is one turn)
    function automatic logic [31:0] sqvt_atan(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BF;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/sqvt_if.sv -----
// valid/ready channels for quads in and vertices out
interface sqvt_quad_if;
    logic               valid;
    logic               ready;
    logic               start_batch;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic [15:0]        angle;
    logic [15:0]        uv_lo_u;
    logic [15:0]        uv_lo_v;
    logic [15:0]        uv_hi_u;
    logic [15:0]        uv_hi_v;

    modport source (
        output valid, start_batch, pos_x, pos_y, size_x, size_y,
               angle, uv_lo_u, uv_lo_v, uv_hi_u, uv_hi_v,
        input  ready
    );
    modport sink (
        input  valid, start_batch, pos_x, pos_y, size_x, size_y,
               angle, uv_lo_u, uv_lo_v, uv_hi_u, uv_hi_v,
        output ready
    );
endinterface

interface sqvt_vert_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [1:0]         corner;
    logic [9:0]         quad_index;
    logic               last_vertex;
    logic               overflow;

    modport source (
        output valid, vert_x, vert_y, tex_u, tex_v, corner, quad_index,
               last_vertex, overflow,
        input  ready
    );
    modport sink (
        input  valid, vert_x, vert_y, tex_u, tex_v, corner, quad_index,
               last_vertex, overflow,
        output ready
    );
endinterface

// ----- rtl/core/sqvt_front.sv -----
// front end: takes quad beats, numbers them within the batch and queues them
module sqvt_front #(
    parameter int MAX_QUADS = sqvt_pkg::SQVT_MAX_QUADS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sqvt_quad_if.sink             quad_in,
    input  sqvt_pkg::sqvt_qstat_t q_stat,
    output sqvt_pkg::sqvt_qpush_t push
);
    import sqvt_pkg::*;

    localparam int CNT_W = $clog2(MAX_QUADS + 1);

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [CNT_W-1:0]              count_eff;
    logic [CNT_W-1:0]              slot;
    logic [CNT_W+SQVT_INDEX_W-1:0] slot_wide;
    logic                          full_batch;
    logic                          accept;

    assign quad_in.ready = !q_stat.full;
    assign accept        = quad_in.valid && !q_stat.full;

    always_comb
    begin
        count_eff  = quad_in.start_batch ? '0 : count_reg;
        full_batch = count_eff >= CNT_W'(MAX_QUADS);
        slot       = full_batch ? CNT_W'(MAX_QUADS - 1) : count_eff;
        count_next = full_batch ? CNT_W'(MAX_QUADS) : count_eff + CNT_W'(1);
        slot_wide  = {{SQVT_INDEX_W{1'b0}}, slot};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        push.valid           = accept;
        push.quad.pos_x      = quad_in.pos_x;
        push.quad.pos_y      = quad_in.pos_y;
        push.quad.size_x     = quad_in.size_x;
        push.quad.size_y     = quad_in.size_y;
        push.quad.angle      = quad_in.angle;
        push.quad.uv_lo_u    = quad_in.uv_lo_u;
        push.quad.uv_lo_v    = quad_in.uv_lo_v;
        push.quad.uv_hi_u    = quad_in.uv_hi_u;
        push.quad.uv_hi_v    = quad_in.uv_hi_v;
        push.quad.quad_index = slot_wide[SQVT_INDEX_W-1:0];
        push.quad.overflow   = full_batch;
    end

endmodule

// ----- rtl/core/sqvt_queue.sv -----
// short fifo of classified quads between front and back
module sqvt_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sqvt_pkg::sqvt_qpush_t push,
    input  logic                  pop,
    output sqvt_pkg::sqvt_quad_t  head,
    output sqvt_pkg::sqvt_qstat_t q_stat
);
    import sqvt_pkg::*;

    localparam int PTR_W = (SQVT_QUEUE_DEPTH > 1) ? $clog2(SQVT_QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(SQVT_QUEUE_DEPTH + 1);

    sqvt_quad_t       entry_reg [SQVT_QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign q_stat.full  = count_reg == CNT_W'(SQVT_QUEUE_DEPTH);
    assign q_stat.empty = count_reg == '0;
    assign do_push      = push.valid && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(SQVT_QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.quad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/sqvt_back.sv -----
// back end: cordic sine/cosine, shared multiplier, corner sums and vertex output register
module sqvt_back #(
    parameter int CORDIC_STEPS = sqvt_pkg::SQVT_CORDIC_STEPS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sqvt_pkg::sqvt_quad_t      head,
    input  sqvt_pkg::sqvt_qstat_t     q_stat,
    output logic                      pop,
    output sqvt_pkg::sqvt_back_stat_t back_stat,
    sqvt_vert_if.source               vert_out
);
    import sqvt_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROT  = 3'd1;
    localparam logic [2:0] ST_FIX  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_SUM  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [STEP_W-1:0]  step_reg;
    logic [1:0]         mul_idx_reg;
    logic [1:0]         corner_reg;
    sqvt_quad_t         quad_reg;
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic signed [33:0] cor_x_reg;
    logic signed [33:0] cor_y_reg;
    logic signed [33:0] cor_z_reg;
    logic               flip_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic signed [63:0] prod_reg [4];
    logic signed [31:0] rot_x_reg;
    logic signed [31:0] rot_y_reg;
    logic               out_valid_reg;
    logic               out_valid_next;

    logic [31:0]        ang_full;
    logic [31:0]        ang_turned;
    logic [31:0]        ang_fold;
    logic               fold;
    logic signed [33:0] x_sh;
    logic signed [33:0] y_sh;
    logic signed [33:0] atan_step;
    logic signed [33:0] x_fin;
    logic signed [33:0] y_fin;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic signed [65:0] term_a;
    logic signed [65:0] term_b;
    logic signed [65:0] term_c;
    logic signed [65:0] term_d;
    logic signed [65:0] sum_x;
    logic signed [65:0] sum_y;
    logic               last_step;
    logic               out_load;

    assign pop                = (state_reg == ST_IDLE) && !q_stat.empty;
    assign back_stat.busy     = state_reg != ST_IDLE;
    assign back_stat.corner   = corner_reg;
    assign last_step          = step_reg == STEP_W'(CORDIC_STEPS - 1);
    assign out_load           = (state_reg == ST_OUT) && (!out_valid_reg || vert_out.ready);

    // fold the left half plane onto the right, undone by negation later
    always_comb
    begin
        ang_full   = {head.angle, 16'h0000};
        ang_turned = ang_full + SQVT_QUARTER_TURN;
        fold       = ang_turned[31];
        ang_fold   = fold ? ang_full + SQVT_HALF_TURN : ang_full;
    end

    always_comb
    begin
        x_sh      = cor_x_reg >>> step_reg;
        y_sh      = cor_y_reg >>> step_reg;
        atan_step = {2'b00, sqvt_atan(5'(step_reg))};
        x_fin     = flip_reg ? -cor_x_reg : cor_x_reg;
        y_fin     = flip_reg ? -cor_y_reg : cor_y_reg;
    end

    // products: sx*cos, sy*sin, sx*sin, sy*cos
    always_comb
    begin
        mul_a = mul_idx_reg[0] ? quad_reg.size_y : quad_reg.size_x;
        mul_b = (mul_idx_reg[0] ^ mul_idx_reg[1]) ? sin_reg : cos_reg;
        mul_p = mul_a * mul_b;
    end

    // corner signs: right corners take +sx, top corners take +sy
    always_comb
    begin
        term_a = corner_reg[0] ? 66'(prod_reg[0]) : -66'(prod_reg[0]);
        term_b = corner_reg[1] ? 66'(prod_reg[1]) : -66'(prod_reg[1]);
        term_c = corner_reg[0] ? 66'(prod_reg[2]) : -66'(prod_reg[2]);
        term_d = corner_reg[1] ? 66'(prod_reg[3]) : -66'(prod_reg[3]);
        sum_x  = term_a - term_b + 66'sd1073741824;
        sum_y  = term_c + term_d + 66'sd1073741824;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (last_step)
                begin
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_idx_reg == 2'd3)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = (corner_reg == CORNER_TR) ? ST_IDLE : ST_SUM;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !vert_out.ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            mul_idx_reg   <= '0;
            corner_reg    <= CORNER_BL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg    <= '0;
                    mul_idx_reg <= '0;
                    corner_reg  <= CORNER_BL;
                end
                ST_ROT:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
                ST_MUL:
                begin
                    mul_idx_reg <= mul_idx_reg + 2'd1;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        corner_reg <= corner_reg + 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    quad_reg     <= head;
                    center_x_reg <= head.pos_x + (head.size_x >>> 1);
                    center_y_reg <= head.pos_y + (head.size_y >>> 1);
                    cor_x_reg    <= {2'b00, SQVT_CORDIC_GAIN};
                    cor_y_reg    <= '0;
                    cor_z_reg    <= {{2{ang_fold[31]}}, ang_fold};
                    flip_reg     <= fold;
                end
            end
            ST_ROT:
            begin
                if (!cor_z_reg[33])
                begin
                    cor_x_reg <= cor_x_reg - y_sh;
                    cor_y_reg <= cor_y_reg + x_sh;
                    cor_z_reg <= cor_z_reg - atan_step;
                end
                else
                begin
                    cor_x_reg <= cor_x_reg + y_sh;
                    cor_y_reg <= cor_y_reg - x_sh;
                    cor_z_reg <= cor_z_reg + atan_step;
                end
            end
            ST_FIX:
            begin
                sin_reg <= y_fin[31:0];
                cos_reg <= x_fin[31:0];
            end
            ST_MUL:
            begin
                prod_reg[mul_idx_reg] <= mul_p;
            end
            ST_SUM:
            begin
                rot_x_reg <= sum_x[62:31];
                rot_y_reg <= sum_y[62:31];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            vert_out.vert_x      <= center_x_reg + rot_x_reg;
            vert_out.vert_y      <= center_y_reg + rot_y_reg;
            vert_out.tex_u       <= corner_reg[0] ? quad_reg.uv_hi_u : quad_reg.uv_lo_u;
            vert_out.tex_v       <= corner_reg[1] ? quad_reg.uv_hi_v : quad_reg.uv_lo_v;
            vert_out.corner      <= corner_reg;
            vert_out.quad_index  <= quad_reg.quad_index;
            vert_out.last_vertex <= corner_reg == CORNER_TR;
            vert_out.overflow    <= quad_reg.overflow;
        end
    end

    assign vert_out.valid = out_valid_reg;

endmodule

// ----- rtl/core/sprite_quad_vertex_transform_core.sv -----
// top level of the sprite quad vertex transform
//
// usage
// - quad_in takes one sprite quad per beat: start flag, lower-left position,
//   size, angle as a fraction of a turn and the two texture corners
// - vert_out gives four vertex beats per quad, bottom-left, bottom-right,
//   top-left, top-right, each with its uvs, corner code, batch slot,
//   last-vertex mark and batch-full flag
// - the front numbers quads at acceptance and parks them in a two-entry
//   queue, so quad_in keeps taking beats while the back is busy
// - in the back a quad is loaded from the queue head, then runs the cordic
//   iterations, the sign fold and four products on the shared 32x32
//   multiplier, then for each corner the sum and the add into the output
//   register; the back pops the next quad only after the last vertex of
//   the current one is loaded
// - reset empties the queue, drops any quad in flight, clears the output
//   valid flag and zeroes the batch counter
// - a stalled vert_out holds its beat; the back waits at the output register
//   and the queue fills, then quad_in drops ready
module sprite_quad_vertex_transform_core #(
    parameter int MAX_QUADS    = sqvt_pkg::SQVT_MAX_QUADS,
    parameter int CORDIC_STEPS = sqvt_pkg::SQVT_CORDIC_STEPS
) (
    input  logic        clk,
    input  logic        rst_n,
    sqvt_quad_if.sink   quad_in,
    sqvt_vert_if.source vert_out
);
    import sqvt_pkg::*;

    sqvt_qpush_t     push;
    sqvt_qstat_t     q_stat;
    sqvt_quad_t      head;
    sqvt_back_stat_t back_stat;
    logic            pop;

    // counter and classification at the input
    sqvt_front #(
        .MAX_QUADS (MAX_QUADS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .quad_in (quad_in),
        .q_stat  (q_stat),
        .push    (push)
    );

    // decouples acceptance from the long per-quad work
    sqvt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .head   (head),
        .q_stat (q_stat)
    );

    // rotation, corner sums and the vertex output register
    sqvt_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .back_stat (back_stat),
        .vert_out  (vert_out)
    );

    // a full batch always reports the last slot
    a_overflow_slot: assert property (@(posedge clk) disable iff (!rst_n)
        vert_out.valid && vert_out.overflow
            |-> vert_out.quad_index == SQVT_INDEX_W'(MAX_QUADS - 1))
        else $error("overflow vertex with wrong slot");

    // after a vertex that is not the last one, the back still owns the quad
    a_quad_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        vert_out.valid && vert_out.ready && !vert_out.last_vertex
            |-> back_stat.busy)
        else $error("back went idle in the middle of a quad");

    // an idle block with an empty queue takes a quad
    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty && !back_stat.busy && !vert_out.valid |-> quad_in.ready)
        else $error("idle block not ready for a quad");

endmodule
